[hdl/isi_pkg.sv]
// ============================================================================
// isi_pkg: shared definitions for the interface state integrator
// Widths, register and function codes, request and result items, and the
// control word that the sequencer hands to the datapath.
// ============================================================================
package isi_pkg;

    localparam int ISI_DATA_W     = 32;
    localparam int ISI_FRAC_BITS  = 16;
    localparam int ISI_H_FRAC     = 16;
    localparam int ISI_H_W        = 16;
    localparam int ISI_LIM_W      = 31;
    localparam int ISI_PROD_W     = 2 * ISI_DATA_W;
    localparam int ISI_CFG_IDX_W  = 3;
    localparam int ISI_CFG_DATA_W = 31;
    localparam int ISI_AXES       = 3;
    localparam int ISI_MAT_N      = ISI_AXES * ISI_AXES;
    localparam int ISI_MAT_IDX_W  = $clog2(ISI_MAT_N);
    localparam int ISI_PC_W       = 5;

    localparam logic [ISI_H_W-1:0]   ISI_STEP_RST = 16'd66;
    localparam logic [ISI_LIM_W-1:0] ISI_LIM_RST  = '1;

    localparam logic [ISI_CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [ISI_CFG_IDX_W-1:0] CFG_STEP   = 3'd1;
    localparam logic [ISI_CFG_IDX_W-1:0] CFG_OLIM_X = 3'd2;
    localparam logic [ISI_CFG_IDX_W-1:0] CFG_OLIM_Y = 3'd3;
    localparam logic [ISI_CFG_IDX_W-1:0] CFG_OLIM_Z = 3'd4;
    localparam logic [ISI_CFG_IDX_W-1:0] CFG_RLIM_X = 3'd5;
    localparam logic [ISI_CFG_IDX_W-1:0] CFG_RLIM_Y = 3'd6;
    localparam logic [ISI_CFG_IDX_W-1:0] CFG_RLIM_Z = 3'd7;

    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_LOAD = 2'd1;
    localparam logic [1:0] FN_OBS  = 2'd2;

    localparam logic [1:0] MD_OFFSET = 2'd1;
    localparam logic [1:0] MD_FULL   = 2'd2;

    localparam logic [1:0] MB_F    = 2'd0;
    localparam logic [1:0] MB_ACC  = 2'd1;
    localparam logic [1:0] MB_RATE = 2'd2;

    localparam logic [2:0] AL_NOP       = 3'd0;
    localparam logic [2:0] AL_WRITE     = 3'd1;
    localparam logic [2:0] AL_FSUM      = 3'd2;
    localparam logic [2:0] AL_ACC_LD    = 3'd3;
    localparam logic [2:0] AL_ACC_ADD   = 3'd4;
    localparam logic [2:0] AL_RATE      = 3'd5;
    localparam logic [2:0] AL_OFF       = 3'd6;
    localparam logic [2:0] AL_OFF_CLAMP = 3'd7;

    localparam logic [1:0] SQ_NEXT     = 2'd0;
    localparam logic [1:0] SQ_DISPATCH = 2'd1;
    localparam logic [1:0] SQ_END      = 2'd2;

    typedef logic signed [ISI_DATA_W-1:0] word_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         row;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] aux_x;
        logic signed [31:0] aux_y;
        logic signed [31:0] aux_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } out_item_t;

    typedef struct packed {
        logic                     mul_en;
        logic                     mul_h;
        logic [ISI_MAT_IDX_W-1:0] mat_idx;
        logic [1:0]               mul_b_sel;
        logic [1:0]               mul_b_idx;
        logic [2:0]               alu_op;
        logic [1:0]               alu_idx;
        logic [1:0]               seq;
    } uword_t;

endpackage

[hdl/isi_stream_if.sv]
// ============================================================================
// isi_stream_if: valid/ready channel
// Carries one request or result per handshake, with the payload type set
// by the instantiating level.
// ============================================================================
interface isi_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

[hdl/interface_state_integrator.sv]
// ============================================================================
// interface_state_integrator: Euler integrator with saturation
// Keeps a three-axis interface offset and rate and an inverse mass matrix,
// and advances, loads or overwrites them one request at a time.
// ============================================================================
// Usage:
// Requests arrive on req (function, row, two vectors) and each one returns
// exactly one result on rsp: the offset and rate after the request.
// Registers are written through cfg_write, cfg_index and cfg_data. Write
// them only while the block is idle; the block itself does not enforce it.
// The mode register selects hold, offset-only or full ticks. A full tick
// runs the longest program, an offset-only tick a shorter one, and loads,
// observations and hold ticks only the dispatch and end steps. The length
// of a full tick is set by the one shared multiplier: fifteen products
// per full tick, issued one a cycle by the control program, with two
// register stages between a product and its write-back. The next request
// is accepted the cycle after the previous one finishes, even while a
// result still waits in the output register. A stalled receiver only
// holds the block once a second result is ready to leave.
// Reset clears offset, rate and matrix, sets the mode to hold, the step to
// 66/65536 s and every limit to its maximum.
// ============================================================================
module interface_state_integrator #(
    parameter int FRAC_BITS = isi_pkg::ISI_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    isi_stream_if.sink                         req,
    isi_stream_if.source                       rsp,
    input  logic                               cfg_write,
    input  logic [isi_pkg::ISI_CFG_IDX_W-1:0]  cfg_index,
    input  logic [isi_pkg::ISI_CFG_DATA_W-1:0] cfg_data
);
    import isi_pkg::*;

    logic [1:0]           mode_reg;
    logic [ISI_H_W-1:0]   step_reg;
    logic [ISI_LIM_W-1:0] olim_reg [ISI_AXES];
    logic [ISI_LIM_W-1:0] rlim_reg [ISI_AXES];

    in_item_t  item_reg;
    out_item_t rsp_payload_reg;
    logic      rsp_valid_reg;

    uword_t    uw;
    out_item_t state;
    logic      busy;
    logic      done;
    logic      start;
    logic      out_free;

    assign req.ready   = !busy;
    assign start       = req.valid && !busy;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            step_reg <= ISI_STEP_RST;
            for (int i = 0; i < ISI_AXES; i++)
            begin
                olim_reg[i] <= ISI_LIM_RST;
                rlim_reg[i] <= ISI_LIM_RST;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg    <= cfg_data[1:0];
                CFG_STEP:   step_reg    <= cfg_data[ISI_H_W-1:0];
                CFG_OLIM_X: olim_reg[0] <= cfg_data;
                CFG_OLIM_Y: olim_reg[1] <= cfg_data;
                CFG_OLIM_Z: olim_reg[2] <= cfg_data;
                CFG_RLIM_X: rlim_reg[0] <= cfg_data;
                CFG_RLIM_Y: rlim_reg[1] <= cfg_data;
                CFG_RLIM_Z: rlim_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            item_reg <= req.payload;
        if (done)
            rsp_payload_reg <= state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (done)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    isi_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .func     (item_reg.func),
        .mode     (mode_reg),
        .out_free (out_free),
        .uw       (uw),
        .busy     (busy),
        .done     (done)
    );

    isi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .uw           (uw),
        .item         (item_reg),
        .step_size    (step_reg),
        .offset_limit (olim_reg),
        .rate_limit   (rlim_reg),
        .state        (state)
    );

`ifndef NO_ASSERTIONS
    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (rsp_valid_reg && rsp_payload_reg == $past(state)))
        else $error("Finished request did not post its result.");
`endif

endmodule

[hdl/isi_sequencer.sv]
// ============================================================================
// isi_sequencer: microprogram store and step counter
// Holds the control program, steps through it one word per cycle while
// not held at an end step, and branches on function and mode at dispatch.
// ============================================================================
module isi_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      func,
    input  logic [1:0]      mode,
    input  logic            out_free,
    output isi_pkg::uword_t uw,
    output logic            busy,
    output logic            done
);
    import isi_pkg::*;

    localparam logic [ISI_PC_W-1:0] PC_DISPATCH = 5'd0;
    localparam logic [ISI_PC_W-1:0] PC_END      = 5'd1;
    localparam logic [ISI_PC_W-1:0] PC_OFFSET   = 5'd2;
    localparam logic [ISI_PC_W-1:0] PC_FULL     = 5'd8;
    localparam logic [ISI_PC_W-1:0] PC_LAST     = 5'd26;

    logic [ISI_PC_W-1:0] pc_reg;
    logic [ISI_PC_W-1:0] pc_next;
    logic                busy_reg;
    logic                busy_next;
    uword_t              uw_rom;

    function automatic uword_t mk(input logic me, input logic mh,
                                  input logic [ISI_MAT_IDX_W-1:0] mi,
                                  input logic [1:0] bs, input logic [1:0] bi,
                                  input logic [2:0] op, input logic [1:0] ai,
                                  input logic [1:0] sq);
        uword_t w;
        w.mul_en    = me;
        w.mul_h     = mh;
        w.mat_idx   = mi;
        w.mul_b_sel = bs;
        w.mul_b_idx = bi;
        w.alu_op    = op;
        w.alu_idx   = ai;
        w.seq       = sq;
        return w;
    endfunction

    always_comb
    begin
        case (pc_reg)
            5'd0:  uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_WRITE,     2'd0, SQ_DISPATCH);
            5'd1:  uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_NOP,       2'd0, SQ_END);
            5'd2:  uw_rom = mk(1'b1, 1'b1, 4'd0, MB_RATE, 2'd0, AL_NOP,       2'd0, SQ_NEXT);
            5'd3:  uw_rom = mk(1'b1, 1'b1, 4'd0, MB_RATE, 2'd1, AL_NOP,       2'd0, SQ_NEXT);
            5'd4:  uw_rom = mk(1'b1, 1'b1, 4'd0, MB_RATE, 2'd2, AL_OFF,       2'd0, SQ_NEXT);
            5'd5:  uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_OFF,       2'd1, SQ_NEXT);
            5'd6:  uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_OFF,       2'd2, SQ_NEXT);
            5'd7:  uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_NOP,       2'd0, SQ_END);
            5'd8:  uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_FSUM,      2'd0, SQ_NEXT);
            5'd9:  uw_rom = mk(1'b1, 1'b0, 4'd0, MB_F,    2'd0, AL_FSUM,      2'd1, SQ_NEXT);
            5'd10: uw_rom = mk(1'b1, 1'b0, 4'd1, MB_F,    2'd1, AL_FSUM,      2'd2, SQ_NEXT);
            5'd11: uw_rom = mk(1'b1, 1'b0, 4'd2, MB_F,    2'd2, AL_ACC_LD,    2'd0, SQ_NEXT);
            5'd12: uw_rom = mk(1'b1, 1'b0, 4'd3, MB_F,    2'd0, AL_ACC_ADD,   2'd0, SQ_NEXT);
            5'd13: uw_rom = mk(1'b1, 1'b0, 4'd4, MB_F,    2'd1, AL_ACC_ADD,   2'd0, SQ_NEXT);
            5'd14: uw_rom = mk(1'b1, 1'b0, 4'd5, MB_F,    2'd2, AL_ACC_LD,    2'd1, SQ_NEXT);
            5'd15: uw_rom = mk(1'b1, 1'b0, 4'd6, MB_F,    2'd0, AL_ACC_ADD,   2'd1, SQ_NEXT);
            5'd16: uw_rom = mk(1'b1, 1'b0, 4'd7, MB_F,    2'd1, AL_ACC_ADD,   2'd1, SQ_NEXT);
            5'd17: uw_rom = mk(1'b1, 1'b0, 4'd8, MB_F,    2'd2, AL_ACC_LD,    2'd2, SQ_NEXT);
            5'd18: uw_rom = mk(1'b1, 1'b1, 4'd0, MB_ACC,  2'd0, AL_ACC_ADD,   2'd2, SQ_NEXT);
            5'd19: uw_rom = mk(1'b1, 1'b1, 4'd0, MB_ACC,  2'd1, AL_ACC_ADD,   2'd2, SQ_NEXT);
            5'd20: uw_rom = mk(1'b1, 1'b1, 4'd0, MB_ACC,  2'd2, AL_RATE,      2'd0, SQ_NEXT);
            5'd21: uw_rom = mk(1'b1, 1'b1, 4'd0, MB_RATE, 2'd0, AL_RATE,      2'd1, SQ_NEXT);
            5'd22: uw_rom = mk(1'b1, 1'b1, 4'd0, MB_RATE, 2'd1, AL_RATE,      2'd2, SQ_NEXT);
            5'd23: uw_rom = mk(1'b1, 1'b1, 4'd0, MB_RATE, 2'd2, AL_OFF_CLAMP, 2'd0, SQ_NEXT);
            5'd24: uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_OFF_CLAMP, 2'd1, SQ_NEXT);
            5'd25: uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_OFF_CLAMP, 2'd2, SQ_NEXT);
            5'd26: uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,    2'd0, AL_NOP,       2'd0, SQ_END);
            default: uw_rom = mk(1'b0, 1'b0, 4'd0, MB_F,  2'd0, AL_NOP,       2'd0, SQ_END);
        endcase
    end

    assign uw   = busy_reg ? uw_rom : mk(1'b0, 1'b0, 4'd0, MB_F, 2'd0, AL_NOP, 2'd0, SQ_NEXT);
    assign busy = busy_reg;
    assign done = busy_reg && (uw_rom.seq == SQ_END) && out_free;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = PC_DISPATCH;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            case (uw_rom.seq)
                SQ_DISPATCH:
                begin
                    if (func == FN_TICK && mode == MD_OFFSET)
                        pc_next = PC_OFFSET;
                    else if (func == FN_TICK && mode == MD_FULL)
                        pc_next = PC_FULL;
                    else
                        pc_next = PC_END;
                end
                SQ_END:  pc_next = pc_reg;
                default: pc_next = pc_reg + ISI_PC_W'(1);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_DISPATCH;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_leave_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(uw_rom.seq == SQ_END))
        else $error("Sequencer went idle outside an end step.");
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= PC_LAST))
        else $error("Step counter ran past the program.");
`endif

endmodule

[hdl/isi_datapath.sv]
// ============================================================================
// isi_datapath: state registers, shared multiplier and saturating adder
// Executes one control word per cycle: a multiply into the product
// register, a scale and saturate stage, and one add, clamp and write-back.
// ============================================================================
module isi_datapath #(
    parameter int FRAC_BITS = isi_pkg::ISI_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  isi_pkg::uword_t              uw,
    input  isi_pkg::in_item_t            item,
    input  logic [isi_pkg::ISI_H_W-1:0]  step_size,
    input  logic [isi_pkg::ISI_LIM_W-1:0] offset_limit [isi_pkg::ISI_AXES],
    input  logic [isi_pkg::ISI_LIM_W-1:0] rate_limit [isi_pkg::ISI_AXES],
    output isi_pkg::out_item_t           state
);
    import isi_pkg::*;

    word_t off_reg  [ISI_AXES];
    word_t rate_reg [ISI_AXES];
    word_t mat_reg  [ISI_MAT_N];
    word_t f_reg    [ISI_AXES];
    word_t acc_reg  [ISI_AXES];
    logic signed [ISI_PROD_W-1:0] prod_reg;
    logic                         prodh_reg;
    word_t scaled_reg;

    word_t vec_arr [ISI_AXES];
    word_t aux_arr [ISI_AXES];
    word_t mul_a;
    word_t mul_b;
    logic signed [ISI_PROD_W-1:0] shifted;
    word_t add_a;
    word_t add_b;
    word_t sum;
    word_t wr_val;
    word_t lim_pos;
    word_t lim_neg;
    logic [ISI_LIM_W-1:0] lim_sel;
    logic clamp_en;

    function automatic word_t sat_word(input logic signed [ISI_PROD_W-1:0] v);
        logic [ISI_PROD_W-ISI_DATA_W:0] top;
        word_t r;
        top = v[ISI_PROD_W-1:ISI_DATA_W-1];
        if (top == '0 || top == '1)
            r = v[ISI_DATA_W-1:0];
        else if (v[ISI_PROD_W-1])
            r = {1'b1, {(ISI_DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(ISI_DATA_W-1){1'b1}}};
        return r;
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [ISI_DATA_W:0] s;
        word_t r;
        s = {a[ISI_DATA_W-1], a} + {b[ISI_DATA_W-1], b};
        if (s[ISI_DATA_W] != s[ISI_DATA_W-1])
            r = s[ISI_DATA_W] ? {1'b1, {(ISI_DATA_W-1){1'b0}}}
                              : {1'b0, {(ISI_DATA_W-1){1'b1}}};
        else
            r = s[ISI_DATA_W-1:0];
        return r;
    endfunction

    assign vec_arr[0] = item.vec_x;
    assign vec_arr[1] = item.vec_y;
    assign vec_arr[2] = item.vec_z;
    assign aux_arr[0] = item.aux_x;
    assign aux_arr[1] = item.aux_y;
    assign aux_arr[2] = item.aux_z;

    always_comb
    begin
        if (uw.mul_h)
            mul_a = $signed({{(ISI_DATA_W-ISI_H_W){1'b0}}, step_size});
        else
            mul_a = mat_reg[uw.mat_idx];
        case (uw.mul_b_sel)
            MB_ACC:  mul_b = acc_reg[uw.mul_b_idx];
            MB_RATE: mul_b = rate_reg[uw.mul_b_idx];
            default: mul_b = f_reg[uw.mul_b_idx];
        endcase
    end

    assign shifted = prodh_reg ? (prod_reg >>> ISI_H_FRAC) : (prod_reg >>> FRAC_BITS);

    always_comb
    begin
        add_a = '0;
        add_b = scaled_reg;
        case (uw.alu_op)
            AL_FSUM:
            begin
                add_a = vec_arr[uw.alu_idx];
                add_b = aux_arr[uw.alu_idx];
            end
            AL_ACC_ADD:          add_a = acc_reg[uw.alu_idx];
            AL_RATE:             add_a = rate_reg[uw.alu_idx];
            AL_OFF, AL_OFF_CLAMP: add_a = off_reg[uw.alu_idx];
            default:             add_a = '0;
        endcase
    end

    assign clamp_en = (uw.alu_op == AL_RATE) || (uw.alu_op == AL_OFF_CLAMP);
    assign lim_sel  = (uw.alu_op == AL_RATE) ? rate_limit[uw.alu_idx]
                                             : offset_limit[uw.alu_idx];
    assign lim_pos  = $signed({1'b0, lim_sel});
    assign lim_neg  = -lim_pos;
    assign sum      = sat_add(add_a, add_b);

    always_comb
    begin
        wr_val = sum;
        if (clamp_en)
        begin
            if (sum > lim_pos)
                wr_val = lim_pos;
            else if (sum < lim_neg)
                wr_val = lim_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ISI_AXES; i++)
            begin
                off_reg[i]  <= '0;
                rate_reg[i] <= '0;
            end
            for (int k = 0; k < ISI_MAT_N; k++)
                mat_reg[k] <= '0;
        end
        else
        begin
            case (uw.alu_op)
                AL_WRITE:
                begin
                    if (item.func == FN_LOAD)
                    begin
                        for (int r = 0; r < ISI_AXES; r++)
                            for (int j = 0; j < ISI_AXES; j++)
                                if (item.row == 2'(r))
                                    mat_reg[ISI_AXES * r + j] <= vec_arr[j];
                    end
                    else if (item.func == FN_OBS)
                    begin
                        for (int i = 0; i < ISI_AXES; i++)
                        begin
                            off_reg[i]  <= vec_arr[i];
                            rate_reg[i] <= aux_arr[i];
                        end
                    end
                end
                AL_RATE:              rate_reg[uw.alu_idx] <= wr_val;
                AL_OFF, AL_OFF_CLAMP: off_reg[uw.alu_idx]  <= wr_val;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.mul_en)
        begin
            prod_reg  <= mul_a * mul_b;
            prodh_reg <= uw.mul_h;
        end
        scaled_reg <= sat_word(shifted);
        case (uw.alu_op)
            AL_FSUM:               f_reg[uw.alu_idx]   <= wr_val;
            AL_ACC_LD, AL_ACC_ADD: acc_reg[uw.alu_idx] <= wr_val;
            default:
            begin
            end
        endcase
    end

    assign state.offset_x = off_reg[0];
    assign state.offset_y = off_reg[1];
    assign state.offset_z = off_reg[2];
    assign state.rate_x   = rate_reg[0];
    assign state.rate_y   = rate_reg[1];
    assign state.rate_z   = rate_reg[2];

`ifndef NO_ASSERTIONS
    a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clamp_en |-> (wr_val <= lim_pos && wr_val >= lim_neg))
        else $error("Clamped value lies outside its limit.");
    a_alu_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.alu_op != AL_NOP && uw.alu_op != AL_WRITE) |-> (uw.alu_idx < 2'(ISI_AXES)))
        else $error("Write-back addresses a missing axis.");
    a_mul_operands: assert property (@(posedge clk) disable iff (!rst_n)
        uw.mul_en |-> (uw.mul_b_idx < 2'(ISI_AXES)
                       && (uw.mul_h || uw.mat_idx < ISI_MAT_IDX_W'(ISI_MAT_N))))
        else $error("Multiplier operand index out of range.");
`endif

endmodule
